[src/jse_pkg.sv]
// Shared types, constants and helpers for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

   // Request operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Character constants (7-bit ASCII)
   localparam logic [6:0] CH_QUOTE     = 7'h22;
   localparam logic [6:0] CH_BACKSLASH = 7'h5C;
   localparam logic [6:0] CH_LOWER_U   = 7'h75;
   localparam logic [6:0] CH_ZERO      = 7'h30;
   localparam logic [6:0] CH_UPPER_F   = 7'h46;
   localparam logic [6:0] CH_UPPER_D   = 7'h44;

   // Escaped sequences are six characters long
   localparam int unsigned SEQ_LEN = 6;
   localparam int unsigned IDX_W   = $clog2(SEQ_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_LEN - 1);

   // How a held item expands into output characters
   typedef enum logic [1:0] {
      KIND_QUOTE   = 2'd0,
      KIND_PLAIN   = 2'd1,
      KIND_REPLACE = 2'd2,
      KIND_ESCAPE  = 2'd3
   } kind_type;

   // One generated character and its end-of-item flag
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } char_type;

   // Uppercase hex digit for a nibble
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] res;
      if (nib < 4'd10) begin
         res = CH_ZERO + {3'b000, nib};
      end else begin
         res = 7'h41 + {3'b000, nib - 4'd10};
      end
      return res;
   endfunction

   // Printable bytes other than backslash and double quote pass through
   function automatic logic passes_plain(input logic [7:0] b);
      logic res;
      res = (b >= 8'h20) && (b <= 8'h7E) && (b != 8'h5C) && (b != 8'h22);
      return res;
   endfunction

   // Classify a data byte
   function automatic kind_type data_kind(input logic [7:0] b);
      kind_type res;
      if (b[7]) begin
         res = KIND_REPLACE;
      end else if (passes_plain(b)) begin
         res = KIND_PLAIN;
      end else begin
         res = KIND_ESCAPE;
      end
      return res;
   endfunction

endpackage

[src/json_string_escaper.sv]
// Top level of the JSON string escaper: input hold stage and output register.
`timescale 1ns / 1ps

// Turns a byte stream into a quoted JSON string, one request beat per item.
// A start or end beat yields a double quote; a printable data byte other than
// backslash or double quote passes through as one character; a byte with bit 7
// set yields \uFFFD and any other byte yields \u00 plus two uppercase hex
// digits, six characters each. rsp_run_last marks the final character of each
// item; an op of 3 yields nothing. Each response beat carries one character
// from a single output register, so a quote or plain item yields one beat
// and an escaped item six, and a new request is taken in the cycle the previous
// item's last character enters the output register. A request beat passes
// through the hold stage and the output register to the first response beat.
module json_string_escaper
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_byte,
   output logic       rsp_run_last
);

   // Hold stage
   logic             hold_valid_ff, hold_valid_in;
   kind_type         hold_kind_ff, hold_kind_in;
   logic [6:0]       hold_byte_ff, hold_byte_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Output register
   logic             out_valid_ff, out_valid_in;
   char_type         out_char_ff, out_char_in;

   char_type         gen_char;
   logic             out_free;
   logic             emit;
   logic             hold_done;
   logic             req_beat;
   logic             load;

   jse_char_gen u_char_gen (
      .kind      (hold_kind_ff),
      .data_byte (hold_byte_ff),
      .idx       (idx_ff),
      .char_out  (gen_char)
   );

   // Handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = hold_valid_ff && out_free;
   assign hold_done = emit && gen_char.last;
   assign req_stall = hold_valid_ff && !hold_done;
   assign req_beat  = req_valid && !req_stall;
   assign load      = req_beat && (req_op != OP_UNUSED);

   // Hold stage next state
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_byte_in  = hold_byte_ff;
      idx_in        = idx_ff;
      if (hold_done) begin
         hold_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
      if (load) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = req_in_byte[6:0];
         idx_in        = '0;
         if (req_op == OP_DATA) begin
            hold_kind_in = data_kind(req_in_byte);
         end else begin
            hold_kind_in = KIND_QUOTE;
         end
      end
   end

   // Output register next state
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      if (out_free) begin
         out_valid_in = emit;
         if (emit) begin
            out_char_in = gen_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_kind_ff <= hold_kind_in;
      hold_byte_ff <= hold_byte_in;
      out_char_ff  <= out_char_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_char_ff.ch;
   assign rsp_run_last = out_char_ff.last;

endmodule

[src/jse_char_gen.sv]
// Character selector: picks one output character of a held item by index.
`timescale 1ns / 1ps

module jse_char_gen
   import jse_pkg::*;
(
   input  kind_type         kind,
   input  logic [6:0]       data_byte,
   input  logic [IDX_W-1:0] idx,
   output char_type         char_out
);

   logic [6:0] esc_char;
   logic [6:0] rep_char;
   logic       at_end;

   assign at_end = (idx == LAST_IDX);

   // \u00XX sequence
   always_comb begin
      unique case (idx)
         3'd0:    esc_char = CH_BACKSLASH;
         3'd1:    esc_char = CH_LOWER_U;
         3'd2:    esc_char = CH_ZERO;
         3'd3:    esc_char = CH_ZERO;
         3'd4:    esc_char = hex_char({1'b0, data_byte[6:4]});
         default: esc_char = hex_char(data_byte[3:0]);
      endcase
   end

   // \uFFFD sequence
   always_comb begin
      unique case (idx)
         3'd0:    rep_char = CH_BACKSLASH;
         3'd1:    rep_char = CH_LOWER_U;
         3'd2:    rep_char = CH_UPPER_F;
         3'd3:    rep_char = CH_UPPER_F;
         3'd4:    rep_char = CH_UPPER_F;
         default: rep_char = CH_UPPER_D;
      endcase
   end

   // Select by kind; single-character kinds always end the item
   always_comb begin
      unique case (kind)
         KIND_QUOTE: begin
            char_out.ch   = CH_QUOTE;
            char_out.last = 1'b1;
         end
         KIND_PLAIN: begin
            char_out.ch   = data_byte;
            char_out.last = 1'b1;
         end
         KIND_REPLACE: begin
            char_out.ch   = rep_char;
            char_out.last = at_end;
         end
         default: begin
            char_out.ch   = esc_char;
            char_out.last = at_end;
         end
      endcase
   end

endmodule
